[rtl/mre_pkg.sv]
// mre_pkg: shared types, character codes and decimal helpers of the mouse report encoder
// no dependencies; imported by every module of the block

package mre_pkg;

   // configuration register indexes
   localparam logic CSR_TRACKING_MODE = 1'b0;
   localparam logic CSR_EXT_ENCODING  = 1'b1;

   // tracking modes
   localparam logic [2:0] MODE_PRESS_ONLY    = 3'd1;
   localparam logic [2:0] MODE_PRESS_RELEASE = 3'd2;
   localparam logic [2:0] MODE_BUTTON_MOTION = 3'd3;
   localparam logic [2:0] MODE_ANY_MOTION    = 3'd4;

   // event kinds
   localparam logic [2:0] KIND_PRESS      = 3'd0;
   localparam logic [2:0] KIND_RELEASE    = 3'd1;
   localparam logic [2:0] KIND_MOTION     = 3'd2;
   localparam logic [2:0] KIND_WHEEL_UP   = 3'd3;
   localparam logic [2:0] KIND_WHEEL_DOWN = 3'd4;

   localparam logic [1:0] BUTTON_NONE = 2'd3;

   // button byte pieces
   localparam logic [6:0] CB_WHEEL_UP   = 7'd64;
   localparam logic [6:0] CB_WHEEL_DOWN = 7'd65;
   localparam logic [6:0] CB_MOTION     = 7'd32;
   localparam logic [6:0] CB_LEG_REL    = 7'd3;
   localparam logic [6:0] CB_SHIFT      = 7'd4;
   localparam logic [6:0] CB_ALT        = 7'd8;
   localparam logic [6:0] CB_CTRL       = 7'd16;

   // legacy coordinate handling
   localparam logic [7:0]  LEG_BIAS      = 8'd32;
   localparam logic [15:0] LEG_COORD_MAX = 16'd223;

   // sequence characters
   localparam logic [7:0] CH_ESC     = 8'h1B;
   localparam logic [7:0] CH_BRACKET = 8'h5B;
   localparam logic [7:0] CH_LT      = 8'h3C;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_UPPER_M = 8'h4D;
   localparam logic [7:0] CH_LOWER_M = 8'h6D;
   localparam logic [7:0] CH_ZERO    = 8'h30;

   // sgr length is the fixed bytes plus one digit per number plus the extra digits
   localparam logic [4:0]  SGR_BASE_LEN  = 5'd9;

   typedef logic [2:0] pow_type;

   typedef struct packed {
      logic [2:0]         kind;
      logic [1:0]         button;
      logic signed [15:0] column;
      logic signed [15:0] line;
      logic               shift_held;
      logic               alt_held;
      logic               ctrl_held;
   } event_type;

   // decoded transaction handed to the serializer
   typedef struct packed {
      logic        drop;
      logic        sgr;
      logic        release_evt;
      logic [6:0]  cb;
      logic [15:0] cx;
      logic [15:0] cy;
      pow_type     cb_pow;
      pow_type     cx_pow;
      pow_type     cy_pow;
      logic [7:0]  leg_cb;
      logic [7:0]  leg_cx;
      logic [7:0]  leg_cy;
   } job_type;

   typedef enum logic [1:0] {
      NUM_CB,
      NUM_CX,
      NUM_CY
   } num_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ESC,
      ST_CSI,
      ST_LT,
      ST_M,
      ST_LEG_CB,
      ST_LEG_CX,
      ST_LEG_CY,
      ST_DIGIT,
      ST_SEMI,
      ST_FINAL
   } ser_state_type;

   // power of ten by digit position
   function automatic logic [16:0] pow10(pow_type p);
      logic [16:0] r;
      unique case (p)
         3'd0:    r = 17'd1;
         3'd1:    r = 17'd10;
         3'd2:    r = 17'd100;
         3'd3:    r = 17'd1000;
         3'd4:    r = 17'd10000;
         default: r = 17'd0;
      endcase
      return r;
   endfunction

   // k times the power of ten at position p
   function automatic logic [16:0] digit_weight(pow_type p, logic [3:0] k);
      logic [20:0] w;
      w = 21'(pow10(p)) * 21'(k);
      return w[16:0];
   endfunction

   // position of the leading decimal digit
   function automatic pow_type lead_pow(logic [15:0] v);
      pow_type p;
      priority if (v >= 16'd10000) p = 3'd4;
      else if (v >= 16'd1000) p = 3'd3;
      else if (v >= 16'd100) p = 3'd2;
      else if (v >= 16'd10) p = 3'd1;
      else p = 3'd0;
      return p;
   endfunction

endpackage

[rtl/mre_event_decode.sv]
// mre_event_decode: filters one pointer event by mode, builds button byte and coordinates
// depends on mre_pkg

module mre_event_decode #(
   parameter int MAX_SEQ = 32
) (
   input  mre_pkg::event_type evt,
   input  logic [2:0]         tracking_mode,
   input  logic               extended_encoding,
   output mre_pkg::job_type   job
);
   import mre_pkg::*;

   logic        reported;
   logic [6:0]  cb_base;
   logic [6:0]  cb;
   logic [15:0] cx;
   logic [15:0] cy;
   logic [4:0]  seq_len;

   // which events the mode reports
   always_comb begin
      reported = 1'b0;
      if (tracking_mode >= MODE_PRESS_ONLY && tracking_mode <= MODE_ANY_MOTION) begin
         unique case (evt.kind)
            KIND_PRESS, KIND_WHEEL_UP, KIND_WHEEL_DOWN: reported = 1'b1;
            KIND_RELEASE: reported = (tracking_mode != MODE_PRESS_ONLY);
            KIND_MOTION: begin
               reported = (tracking_mode == MODE_ANY_MOTION) ||
                          (tracking_mode == MODE_BUTTON_MOTION && evt.button != BUTTON_NONE);
            end
            default: reported = 1'b0;
         endcase
      end
   end

   // button byte
   always_comb begin
      unique case (evt.kind)
         KIND_WHEEL_UP:   cb_base = CB_WHEEL_UP;
         KIND_WHEEL_DOWN: cb_base = CB_WHEEL_DOWN;
         KIND_MOTION:     cb_base = CB_MOTION + 7'(evt.button);
         KIND_RELEASE:    cb_base = extended_encoding ? 7'(evt.button) : CB_LEG_REL;
         default:         cb_base = 7'(evt.button);
      endcase
      cb = cb_base + (evt.shift_held ? CB_SHIFT : 7'd0) + (evt.alt_held ? CB_ALT : 7'd0)
           + (evt.ctrl_held ? CB_CTRL : 7'd0);
   end

   // one-based coordinates, negatives clamped to zero first
   assign cx = evt.column[15] ? 16'd1 : 16'(evt.column) + 16'd1;
   assign cy = evt.line[15] ? 16'd1 : 16'(evt.line) + 16'd1;

   // sgr length check and transaction fields
   always_comb begin
      job.sgr         = extended_encoding;
      job.release_evt = (evt.kind == KIND_RELEASE);
      job.cb          = cb;
      job.cx          = cx;
      job.cy          = cy;
      job.cb_pow      = lead_pow({9'd0, cb});
      job.cx_pow      = lead_pow(cx);
      job.cy_pow      = lead_pow(cy);
      job.leg_cb      = LEG_BIAS + {1'b0, cb};
      job.leg_cx      = (cx > LEG_COORD_MAX) ? (LEG_BIAS + LEG_COORD_MAX[7:0]) :
                                               (LEG_BIAS + cx[7:0]);
      job.leg_cy      = (cy > LEG_COORD_MAX) ? (LEG_BIAS + LEG_COORD_MAX[7:0]) :
                                               (LEG_BIAS + cy[7:0]);
      seq_len         = SGR_BASE_LEN + 5'(job.cb_pow) + 5'(job.cx_pow) + 5'(job.cy_pow);
      job.drop        = !reported || (extended_encoding && int'(seq_len) >= MAX_SEQ);
   end

endmodule

[rtl/mre_byte_serializer.sv]
// mre_byte_serializer: streams a decoded report one byte per cycle unless stalled,
// decimal digits extracted one per cycle; holds result register. depends on mre_pkg

module mre_byte_serializer (
   input  logic             clock,
   input  logic             reset,
   input  mre_pkg::job_type job,
   input  logic             load,
   output logic             can_load,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_seq_byte,
   output logic             rsp_seq_last
);
   import mre_pkg::*;

   ser_state_type state_ff, state_in;
   job_type       job_ff;
   logic [15:0]   num_ff, num_in;
   pow_type       pow_ff, pow_in;
   num_sel_type   sel_ff, sel_in;
   logic          rsp_valid_ff;
   logic [7:0]    rsp_byte_ff;
   logic          rsp_last_ff;

   logic          out_free;
   logic          adv;
   logic [7:0]    cur_byte;
   logic          cur_last;
   logic [3:0]    digit;
   logic [16:0]   rem;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign adv      = (state_ff != ST_IDLE) && out_free;
   assign can_load = (state_ff == ST_IDLE) || (adv && cur_last);

   // current decimal digit by parallel compares against its weights
   always_comb begin
      digit = 4'd0;
      for (int k = 1; k < 10; k++) begin
         if ({1'b0, num_ff} >= digit_weight(pow_ff, 4'(k))) digit = 4'(k);
      end
      rem = {1'b0, num_ff} - digit_weight(pow_ff, digit);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      if (load) begin
         state_in = ST_ESC;
      end else if (adv) begin
         unique case (state_ff)
            ST_ESC:    state_in = ST_CSI;
            ST_CSI:    state_in = job_ff.sgr ? ST_LT : ST_M;
            ST_LT:     state_in = ST_DIGIT;
            ST_M:      state_in = ST_LEG_CB;
            ST_LEG_CB: state_in = ST_LEG_CX;
            ST_LEG_CX: state_in = ST_LEG_CY;
            ST_LEG_CY: state_in = ST_IDLE;
            ST_DIGIT: begin
               if (pow_ff == 3'd0) state_in = (sel_ff == NUM_CY) ? ST_FINAL : ST_SEMI;
               else state_in = ST_DIGIT;
            end
            ST_SEMI:   state_in = ST_DIGIT;
            ST_FINAL:  state_in = ST_IDLE;
            default:   state_in = ST_IDLE;
         endcase
      end
   end

   // byte and last flag of the current state
   always_comb begin
      cur_byte = CH_ESC;
      cur_last = 1'b0;
      unique case (state_ff)
         ST_ESC:    cur_byte = CH_ESC;
         ST_CSI:    cur_byte = CH_BRACKET;
         ST_LT:     cur_byte = CH_LT;
         ST_M:      cur_byte = CH_UPPER_M;
         ST_LEG_CB: cur_byte = job_ff.leg_cb;
         ST_LEG_CX: cur_byte = job_ff.leg_cx;
         ST_LEG_CY: begin
            cur_byte = job_ff.leg_cy;
            cur_last = 1'b1;
         end
         ST_DIGIT:  cur_byte = CH_ZERO + {4'd0, digit};
         ST_SEMI:   cur_byte = CH_SEMI;
         ST_FINAL: begin
            cur_byte = job_ff.release_evt ? CH_LOWER_M : CH_UPPER_M;
            cur_last = 1'b1;
         end
         default:   cur_byte = CH_ESC;
      endcase
   end

   // number walker: loads each number and steps down its digit positions
   always_comb begin
      num_in = num_ff;
      pow_in = pow_ff;
      sel_in = sel_ff;
      if (adv) begin
         unique case (state_ff)
            ST_LT: begin
               num_in = {9'd0, job_ff.cb};
               pow_in = job_ff.cb_pow;
               sel_in = NUM_CB;
            end
            ST_DIGIT: begin
               num_in = rem[15:0];
               pow_in = (pow_ff == 3'd0) ? pow_ff : pow_ff - 3'd1;
            end
            ST_SEMI: begin
               if (sel_ff == NUM_CB) begin
                  num_in = job_ff.cx;
                  pow_in = job_ff.cx_pow;
                  sel_in = NUM_CX;
               end else begin
                  num_in = job_ff.cy;
                  pow_in = job_ff.cy_pow;
                  sel_in = NUM_CY;
               end
            end
            default: begin
               num_in = num_ff;
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (adv) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (load) job_ff <= job;
      num_ff <= num_in;
      pow_ff <= pow_in;
      sel_ff <= sel_in;
      if (adv) begin
         rsp_byte_ff <= cur_byte;
         rsp_last_ff <= cur_last;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_seq_byte = rsp_byte_ff;
   assign rsp_seq_last = rsp_last_ff;

   // a new transaction only enters an idle or finishing serializer
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> (state_ff == ST_IDLE || (adv && cur_last)))
      else $error("serializer loaded while busy");

   // every report starts with the escape byte
   a_esc_first: assert property (@(posedge clock) disable iff (reset)
      (adv && state_ff == ST_ESC) |=> (rsp_valid && rsp_seq_byte == CH_ESC && !rsp_seq_last))
      else $error("report did not start with escape");

   // the units digit leaves a remainder below ten
   a_units_digit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIGIT && pow_ff == 3'd0) |-> (num_ff <= 16'd9))
      else $error("decimal remainder out of range");

   // digit positions never exceed five digits
   a_pow_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIGIT) |-> (pow_ff <= 3'd4))
      else $error("digit position out of range");

endmodule

[rtl/mouse_report_encoder.sv]
// mouse_report_encoder: top level, input register, configuration registers and the serializer
// depends on mre_pkg, mre_event_decode and mre_byte_serializer

// Encodes one pointer event per req_ transaction into a terminal mouse report, streamed one
// byte per rsp_ transaction with rsp_seq_last on the final byte. Legacy encoding gives six
// bytes; SGR encoding gives 9 to 18 bytes (six fixed bytes plus the decimal digits of the
// button byte and both coordinates). An event occupies the byte serializer until it has
// emitted its last byte; the next event is decoded in the input register while the current
// one streams, and an event that the tracking mode filters out, or an SGR report of MAX_SEQ
// bytes or more, is discarded with no output. Configuration is written through csr_wr_en,
// csr_index and csr_wr_data; the user must write it only while no transaction is in flight,
// as the block itself does not enforce this.

module mouse_report_encoder #(
   parameter int MAX_SEQ = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_kind,
   input  logic [1:0]         req_button,
   input  logic signed [15:0] req_column,
   input  logic signed [15:0] req_line,
   input  logic               req_shift_held,
   input  logic               req_alt_held,
   input  logic               req_ctrl_held,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_seq_byte,
   output logic               rsp_seq_last,
   input  logic               csr_wr_en,
   input  logic               csr_index,
   input  logic [2:0]         csr_wr_data
);
   import mre_pkg::*;

   logic [2:0] tracking_mode_ff;
   logic       ext_encoding_ff;
   logic       evt_valid_ff;
   event_type  evt_ff;
   job_type    job;
   logic       can_load;
   logic       load;
   logic       evt_take;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tracking_mode_ff <= 3'd0;
         ext_encoding_ff  <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TRACKING_MODE: tracking_mode_ff <= csr_wr_data;
            CSR_EXT_ENCODING:  ext_encoding_ff  <= csr_wr_data[0];
            default:           ext_encoding_ff  <= ext_encoding_ff;
         endcase
      end
   end

   // input register hand-off
   assign load      = evt_valid_ff && !job.drop && can_load;
   assign evt_take  = evt_valid_ff && (job.drop || can_load);
   assign req_ready = !evt_valid_ff || evt_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         evt_valid_ff <= 1'b0;
      end else if (req_ready) begin
         evt_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         evt_ff.kind       <= req_kind;
         evt_ff.button     <= req_button;
         evt_ff.column     <= req_column;
         evt_ff.line       <= req_line;
         evt_ff.shift_held <= req_shift_held;
         evt_ff.alt_held   <= req_alt_held;
         evt_ff.ctrl_held  <= req_ctrl_held;
      end
   end

   // event filter and field build
   mre_event_decode #(
      .MAX_SEQ(MAX_SEQ)
   ) u_decode (
      .evt              (evt_ff),
      .tracking_mode    (tracking_mode_ff),
      .extended_encoding(ext_encoding_ff),
      .job              (job)
   );

   // byte stream
   mre_byte_serializer u_serializer (
      .clock       (clock),
      .reset       (reset),
      .job         (job),
      .load        (load),
      .can_load    (can_load),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_seq_byte(rsp_seq_byte),
      .rsp_seq_last(rsp_seq_last)
   );

endmodule

[tb/tb_mouse_report_encoder.sv]
// tb_mouse_report_encoder: self-checking testbench for the mouse report encoder
// depends on mre_pkg and mouse_report_encoder; predicts every report byte and checks the stream

module tb_mouse_report_encoder;
   import mre_pkg::*;

   localparam int MAX_SEQ       = 32;
   localparam int IDLE_PCT      = 14;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES   = 400;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int PRINT_LIMIT   = 30;

   // codes that the package leaves unnamed
   localparam logic [2:0] MODE_OFF          = 3'd0;
   localparam logic [2:0] MODE_UNUSED_TOP   = 3'd7;
   localparam logic [2:0] KIND_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] KIND_UNUSED_MID   = 3'd6;
   localparam logic [2:0] KIND_UNUSED_LAST  = 3'd7;
   localparam logic [1:0] BUTTON_LEFT       = 2'd0;
   localparam logic [1:0] BUTTON_MIDDLE     = 2'd1;
   localparam logic [1:0] BUTTON_RIGHT      = 2'd2;
   localparam logic       ENC_LEGACY        = 1'b0;
   localparam logic       ENC_SGR           = 1'b1;
   // modifier sets as {ctrl, alt, shift}
   localparam logic [2:0] MODS_NONE         = 3'b000;
   localparam logic [2:0] MODS_SHIFT        = 3'b001;
   localparam logic [2:0] MODS_ALT          = 3'b010;
   localparam logic [2:0] MODS_CTRL         = 3'b100;
   localparam logic [2:0] MODS_ALL          = 3'b111;

   typedef struct packed {
      logic [7:0] seq_byte;
      logic       seq_last;
   } report_byte_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [2:0]         req_kind;
   logic [1:0]         req_button;
   logic signed [15:0] req_column;
   logic signed [15:0] req_line;
   logic               req_shift_held;
   logic               req_alt_held;
   logic               req_ctrl_held;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [7:0]         rsp_seq_byte;
   logic               rsp_seq_last;
   logic               csr_wr_en;
   logic               csr_index;
   logic [2:0]         csr_wr_data;

   // testbench copy of the configuration
   logic [2:0]   mode_setting;
   logic         sgr_setting;

   report_byte_type expected_bytes[$];
   int              error_count;
   int              cycle_count;
   bit              quiet_mode;
   int              hold_req;
   int              hold_ack;
   int              hold_left;

   mouse_report_encoder #(
      .MAX_SEQ(MAX_SEQ)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_button    (req_button),
      .req_column    (req_column),
      .req_line      (req_line),
      .req_shift_held(req_shift_held),
      .req_alt_held  (req_alt_held),
      .req_ctrl_held (req_ctrl_held),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_seq_byte  (rsp_seq_byte),
      .rsp_seq_last  (rsp_seq_last),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data)
   );

   // clock, period 10
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // known values on every input from time zero
   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_kind       = '0;
      req_button     = '0;
      req_column     = '0;
      req_line       = '0;
      req_shift_held = 1'b0;
      req_alt_held   = 1'b0;
      req_ctrl_held  = 1'b0;
      rsp_ready      = 1'b0;
      csr_wr_en      = 1'b0;
      csr_index      = 1'b0;
      csr_wr_data    = '0;
      mode_setting   = MODE_OFF;
      sgr_setting    = ENC_LEGACY;
      error_count    = 0;
      cycle_count    = 0;
      quiet_mode     = 1'b0;
      hold_req       = 0;
      hold_ack       = 0;
      hold_left      = 0;
   end

   task automatic report_mismatch(input string what);
      if (error_count < PRINT_LIMIT)
         $display("mismatch at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // event filter for the current tracking mode
   function automatic bit is_reportable(logic [2:0] mode, logic [2:0] kind,
                                        logic [1:0] button);
      if (mode < MODE_PRESS_ONLY || mode > MODE_ANY_MOTION) return 1'b0;
      case (kind)
         KIND_PRESS, KIND_WHEEL_UP, KIND_WHEEL_DOWN: return 1'b1;
         KIND_RELEASE: return mode != MODE_PRESS_ONLY;
         KIND_MOTION: begin
            if (mode == MODE_ANY_MOTION) return 1'b1;
            return mode == MODE_BUTTON_MOTION && button != BUTTON_NONE;
         end
         default: return 1'b0;
      endcase
   endfunction

   // one-based coordinate with negatives clamped to zero
   function automatic int unsigned one_based(logic signed [15:0] raw);
      if (raw[15]) return 1;
      return int'(raw[14:0]) + 1;
   endfunction

   // works out the report bytes of one accepted event
   task automatic predict_report(input event_type ev);
      int unsigned     cb;
      int unsigned     cx;
      int unsigned     cy;
      string           seq;
      logic [7:0]      final_char;
      report_byte_type rb;
      if (!is_reportable(mode_setting, ev.kind, ev.button)) return;
      cx = one_based(ev.column);
      cy = one_based(ev.line);
      case (ev.kind)
         KIND_WHEEL_UP:   cb = CB_WHEEL_UP;
         KIND_WHEEL_DOWN: cb = CB_WHEEL_DOWN;
         KIND_MOTION:     cb = CB_MOTION + ev.button;
         KIND_RELEASE:    cb = sgr_setting ? ev.button : CB_LEG_REL;
         default:         cb = ev.button;
      endcase
      if (ev.shift_held) cb += CB_SHIFT;
      if (ev.alt_held) cb += CB_ALT;
      if (ev.ctrl_held) cb += CB_CTRL;

      if (sgr_setting) begin
         final_char = (ev.kind == KIND_RELEASE) ? CH_LOWER_M : CH_UPPER_M;
         seq = $sformatf("%c%c%c%0d%c%0d%c%0d%c", CH_ESC, CH_BRACKET, CH_LT, cb, CH_SEMI,
                         cx, CH_SEMI, cy, final_char);
         // long sequences are suppressed entirely
         if (seq.len() >= MAX_SEQ) return;
         for (int i = 0; i < seq.len(); i++) begin
            rb.seq_byte = seq[i];
            rb.seq_last = (i == seq.len() - 1);
            expected_bytes.push_back(rb);
         end
      end else begin
         if (cx > LEG_COORD_MAX) cx = LEG_COORD_MAX;
         if (cy > LEG_COORD_MAX) cy = LEG_COORD_MAX;
         expected_bytes.push_back('{CH_ESC, 1'b0});
         expected_bytes.push_back('{CH_BRACKET, 1'b0});
         expected_bytes.push_back('{CH_UPPER_M, 1'b0});
         expected_bytes.push_back('{8'(LEG_BIAS + cb), 1'b0});
         expected_bytes.push_back('{8'(LEG_BIAS + cx), 1'b0});
         expected_bytes.push_back('{8'(LEG_BIAS + cy), 1'b1});
      end
   endtask

   // receiver: random stalls, long hold on request, byte check
   always @(posedge clock) begin
      report_byte_type exp_b;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %02h last %0b", rsp_seq_byte,
                                      rsp_seq_last));
         end else begin
            exp_b = expected_bytes.pop_front();
            if (rsp_seq_byte !== exp_b.seq_byte)
               report_mismatch($sformatf("seq_byte %02h, expected %02h", rsp_seq_byte,
                                         exp_b.seq_byte));
            if (rsp_seq_last !== exp_b.seq_last)
               report_mismatch($sformatf("seq_last %0b, expected %0b", rsp_seq_last,
                                         exp_b.seq_last));
         end
      end
      if (hold_ack != hold_req) begin
         hold_ack = hold_req;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= quiet_mode || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // offers one event and waits for its transaction, with random idle cycles first
   task automatic send_event(input event_type ev);
      while (!quiet_mode && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= ev.kind;
      req_button     <= ev.button;
      req_column     <= ev.column;
      req_line       <= ev.line;
      req_shift_held <= ev.shift_held;
      req_alt_held   <= ev.alt_held;
      req_ctrl_held  <= ev.ctrl_held;
      do @(posedge clock); while (!req_ready);
      predict_report(ev);
   endtask

   // drain all expected bytes, then let dropped events clear the pipeline
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // writes both registers while the block is idle
   task automatic set_config(input logic [2:0] mode, input logic enc);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_TRACKING_MODE;
      csr_wr_data <= mode;
      @(posedge clock);
      mode_setting = mode;
      csr_index   <= CSR_EXT_ENCODING;
      // upper data bits are don't-care for the encoding register
      csr_wr_data <= {2'($urandom), enc};
      @(posedge clock);
      sgr_setting = enc;
      csr_wr_en   <= 1'b0;
   endtask

   function automatic event_type make_event(logic [2:0] kind, logic [1:0] button,
                                            logic signed [15:0] column,
                                            logic signed [15:0] line, logic [2:0] mods);
      event_type ev;
      ev.kind       = kind;
      ev.button     = button;
      ev.column     = column;
      ev.line       = line;
      ev.shift_held = mods[0];
      ev.alt_held   = mods[1];
      ev.ctrl_held  = mods[2];
      return ev;
   endfunction

   // coordinates biased toward the legacy clamp and digit-count boundaries
   function automatic logic signed [15:0] random_coord();
      case ($urandom_range(9))
         0, 1, 2: return 16'($urandom_range(0, 230));
         3:       return 16'($urandom_range(218, 228));
         4:       return 16'($urandom_range(0, 32767));
         5:       return {1'b1, 15'($urandom)};
         6:       return 16'($urandom_range(8, 10000));
         7:       return 16'($urandom);
         8:       return 16'($urandom_range(9998, 10000));
         default: begin
            case ($urandom_range(3))
               0:       return 16'sh7FFF;
               1:       return 16'sh8000;
               2:       return 16'sh0000;
               default: return 16'shFFFF;
            endcase
         end
      endcase
   endfunction

   // mostly valid kinds, a few unused codes as noise
   function automatic event_type random_event();
      logic [2:0] kind;
      if ($urandom_range(99) < 92) kind = 3'($urandom_range(KIND_PRESS, KIND_WHEEL_DOWN));
      else kind = 3'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST));
      return make_event(kind, 2'($urandom), random_coord(), random_coord(), 3'($urandom));
   endfunction

   // reset defaults: tracking off, nothing reported
   task automatic test_tracking_off();
      send_event(make_event(KIND_PRESS, BUTTON_LEFT, 16'sd5, 16'sd5, MODS_NONE));
      send_event(make_event(KIND_WHEEL_UP, BUTTON_NONE, 16'sd0, 16'sd0, MODS_ALL));
      // unused tracking mode acts as off
      set_config(MODE_UNUSED_TOP, ENC_SGR);
      send_event(make_event(KIND_PRESS, BUTTON_RIGHT, 16'sd1, 16'sd2, MODS_SHIFT));
   endtask

   // legacy bytes: every kind, clamps, negatives, unused kinds
   task automatic test_legacy_encoding();
      set_config(MODE_ANY_MOTION, ENC_LEGACY);
      send_event(make_event(KIND_PRESS, BUTTON_LEFT, 16'sd0, 16'sd0, MODS_NONE));
      send_event(make_event(KIND_RELEASE, BUTTON_MIDDLE, 16'sd222, 16'sd223, MODS_ALL));
      send_event(make_event(KIND_MOTION, BUTTON_NONE, 16'sh7FFF, -16'sd1, MODS_ALT));
      send_event(make_event(KIND_WHEEL_UP, BUTTON_LEFT, 16'sh8000, 16'sd500, MODS_CTRL));
      send_event(make_event(KIND_WHEEL_DOWN, BUTTON_RIGHT, 16'sd221, 16'sd224, MODS_SHIFT));
      send_event(make_event(KIND_UNUSED_FIRST, BUTTON_LEFT, 16'sd3, 16'sd3, MODS_NONE));
      send_event(make_event(KIND_UNUSED_LAST, BUTTON_NONE, 16'sd3, 16'sd3, MODS_ALL));
   endtask

   // sgr decimal form, longest sequence and lower-case release
   task automatic test_sgr_encoding();
      set_config(MODE_ANY_MOTION, ENC_SGR);
      send_event(make_event(KIND_PRESS, BUTTON_LEFT, 16'sh7FFF, 16'sh7FFF, MODS_ALL));
      send_event(make_event(KIND_RELEASE, BUTTON_RIGHT, 16'sd9, 16'sd99, MODS_NONE));
      send_event(make_event(KIND_MOTION, BUTTON_MIDDLE, 16'sh8000, 16'sd9999, MODS_SHIFT));
      send_event(make_event(KIND_WHEEL_DOWN, BUTTON_NONE, 16'sd998, 16'sd0, MODS_ALL));
      send_event(make_event(KIND_WHEEL_UP, BUTTON_LEFT, 16'sd0, 16'sd0, MODS_NONE));
      send_event(make_event(KIND_UNUSED_MID, BUTTON_MIDDLE, 16'sd4, 16'sd4, MODS_NONE));
   endtask

   // filtering in press-only, press-release and button-motion modes
   task automatic test_mode_filtering();
      set_config(MODE_PRESS_ONLY, ENC_LEGACY);
      send_event(make_event(KIND_PRESS, BUTTON_RIGHT, 16'sd10, 16'sd20, MODS_NONE));
      send_event(make_event(KIND_RELEASE, BUTTON_RIGHT, 16'sd10, 16'sd20, MODS_NONE));
      send_event(make_event(KIND_MOTION, BUTTON_LEFT, 16'sd11, 16'sd20, MODS_NONE));
      set_config(MODE_PRESS_RELEASE, ENC_SGR);
      send_event(make_event(KIND_RELEASE, BUTTON_LEFT, 16'sd30, 16'sd40, MODS_CTRL));
      send_event(make_event(KIND_MOTION, BUTTON_LEFT, 16'sd31, 16'sd40, MODS_NONE));
      set_config(MODE_BUTTON_MOTION, ENC_LEGACY);
      send_event(make_event(KIND_MOTION, BUTTON_LEFT, 16'sd50, 16'sd60, MODS_NONE));
      send_event(make_event(KIND_MOTION, BUTTON_NONE, 16'sd51, 16'sd60, MODS_NONE));
   endtask

   // random events across a sweep of register settings
   task automatic test_random_traffic();
      logic [2:0] modes[9];
      logic       encs[9];
      int         counts[9];
      modes  = '{MODE_PRESS_ONLY, MODE_PRESS_RELEASE, MODE_BUTTON_MOTION, MODE_ANY_MOTION,
                 MODE_ANY_MOTION, MODE_BUTTON_MOTION, MODE_OFF, MODE_UNUSED_TOP,
                 MODE_PRESS_RELEASE};
      encs   = '{ENC_LEGACY, ENC_SGR, ENC_LEGACY, ENC_SGR, ENC_LEGACY, ENC_SGR, ENC_SGR,
                 ENC_LEGACY, ENC_LEGACY};
      counts = '{15, 15, 15, 15, 15, 15, 4, 4, 16};
      foreach (modes[p]) begin
         set_config(modes[p], encs[p]);
         repeat (counts[p]) send_event(random_event());
      end
      // a few fully random settings, unused modes included
      repeat (3) begin
         set_config(3'($urandom), 1'($urandom));
         repeat (15) send_event(random_event());
      end
   endtask

   // no idling on either side
   task automatic test_quiet_stretch();
      set_config(MODE_ANY_MOTION, ENC_SGR);
      quiet_mode = 1'b1;
      repeat (40) send_event(random_event());
      wait_idle();
      quiet_mode = 1'b0;
   endtask

   // receiver holds off while events keep coming, so the input stalls
   task automatic test_backpressure();
      set_config(MODE_ANY_MOTION, ENC_LEGACY);
      hold_req = hold_req + 1;
      repeat (24) send_event(random_event());
      set_config(MODE_ANY_MOTION, ENC_SGR);
      hold_req = hold_req + 1;
      repeat (24) send_event(random_event());
   endtask

   // sequence of tests and the final verdict
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_tracking_off();
      test_legacy_encoding();
      test_sgr_encoding();
      test_mode_filtering();
      test_random_traffic();
      test_quiet_stretch();
      test_backpressure();
      wait_idle();
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/mre_pkg.sv
rtl/mre_event_decode.sv
rtl/mre_byte_serializer.sv
rtl/mouse_report_encoder.sv
tb/tb_mouse_report_encoder.sv
